// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file lru_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/lru_pkg.sv
// Shared types and constants for the LRU table with use counts.
// No dependencies.
package lru_pkg;
  localparam int Capacity  = 16;
  localparam int SlotBits  = 4;
  localparam int KeyBits   = 32;
  localparam int CountBits = 8;
  localparam int OccBits   = 5;
  localparam logic [CountBits-1:0] CountMax = '1;

  localparam logic [1:0] OP_LOCATE = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_DEACT  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_LOCATE = 2'd0;
  localparam logic [1:0] KIND_EVICT  = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LSCAN, ST_LUPD, ST_LRES, ST_FRD, ST_FWR,
    ST_ESCAN, ST_EDO, ST_OUT
  } state_t;
endpackage

// File: hw/rtl/lru_evictor_with_pin_counts.sv
// LRU table of keyed entries with use counts: top level.
// Depends on lru_pkg and lru_ram (entry keys and recency ranks).
//
// Usage:
//   s_axis: tdata = {handle, create_ok, key, op} from bit 0, one request
//   per transaction. m_axis: tdata = {evicted_key, slot, granted, found}
//   from bit 0, tuser = kind, tlast marks the final result of a request.
//   cfg_we/cfg_wdata writes size_limit (reset 16); the user must write it
//   only while idle, as the block does not enforce it. One request at a
//   time. A scan pass reads the key/rank memories once per slot. A locate
//   answer follows a search pass, a rank update pass and a result state. A
//   finish request decrements the handle's use count, then runs a scan and
//   decision pass; if nothing is evicted its one result is the empty
//   answer, otherwise each eviction costs one more scan and decision pass.
//   Deactivate skips the count update. s_axis_tready rises once the final
//   result is taken and the output state is left. Each result waits in an
//   output register; a stalled receiver halts the block until the result
//   is taken. Reset empties the table at once (valid bits and use counts
//   in flops); key and rank memories need no clearing.
module lru_evictor_with_pin_counts (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // op[1:0], key[33:2], create_ok[34], handle[38:35]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // found[0], granted[1], slot[5:2], evicted_key[37:6]
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  localparam int SB = lru_pkg::SlotBits;
  localparam int KB = lru_pkg::KeyBits;
  localparam int CB = lru_pkg::CountBits;
  localparam int OB = lru_pkg::OccBits;

  lru_pkg::state_t state, state_next;

  logic [lru_pkg::Capacity-1:0] valid;
  logic [CB-1:0] cnt [lru_pkg::Capacity];
  logic [OB-1:0] occ, limit;
  logic deact;

  logic [KB-1:0] key;
  logic create_ok;
  logic [SB-1:0] handle;

  // scan: addr issued, pipe tracks which slot the read data belongs to
  logic [OB-1:0] scan;
  logic          rd_vld;
  logic [SB-1:0] rd_slot;
  logic          hit;
  logic [SB-1:0] hit_slot;
  logic [SB-1:0] hit_rank;
  logic [OB-1:0] tries;
  logic [SB-1:0] tail;
  logic          tail_ok;
  logic          nev;
  logic [KB-1:0] k_rdata_tail;
  logic [SB-1:0] hold_slot;
  logic [KB-1:0] hold_key;

  // memories
  logic          k_we, r_we;
  logic [SB-1:0] k_waddr, r_waddr, raddr;
  logic [KB-1:0] k_wdata, k_rdata;
  logic [SB-1:0] r_wdata, r_rdata;

  lru_ram #(.Width(KB), .Depth(lru_pkg::Capacity)) u_keys (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr, .rdata(k_rdata));
  lru_ram #(.Width(SB), .Depth(lru_pkg::Capacity)) u_rank (
    .clk, .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr, .rdata(r_rdata));

  // free slot: lowest invalid index
  logic          free_ok;
  logic [SB-1:0] free_slot;
  always_comb begin
    free_ok = 1'b0;
    free_slot = '0;
    for (int i = lru_pkg::Capacity - 1; i >= 0; i--)
      if (!valid[i]) begin
        free_ok = 1'b1;
        free_slot = SB'(i);
      end
  end

  logic [OB-1:0] eff_limit;
  assign eff_limit = deact ? '0 : limit;

  assign raddr = scan[SB-1:0];
  assign s_axis_tready = (state == lru_pkg::ST_IDLE);
  logic scan_end;
  assign scan_end = (scan == OB'(lru_pkg::Capacity));
  logic scan_run;
  assign scan_run = (state == lru_pkg::ST_LSCAN || state == lru_pkg::ST_LUPD ||
                     state == lru_pkg::ST_ESCAN) && !scan_end;

  // output register
  logic out_busy;
  logic out_free;
  assign m_axis_tvalid = out_busy;
  assign out_free = !out_busy || m_axis_tready;

  // eviction decision at end of tail scan; a held eviction goes out once the next is known
  logic evict_now;
  logic edo_emit;
  logic edo_go;
  logic out_load;
  assign evict_now = (tries != '0) && (occ != '0) && tail_ok && (cnt[tail] == '0);
  assign edo_emit = nev || !evict_now;
  assign edo_go = !edo_emit || out_free;
  assign out_load = (state == lru_pkg::ST_LRES) ||
                    (state == lru_pkg::ST_EDO && edo_emit && out_free);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lru_pkg::ST_IDLE:
        if (s_axis_tvalid) begin
          unique case (s_axis_tdata[1:0])
            lru_pkg::OP_LOCATE: state_next = lru_pkg::ST_LSCAN;
            lru_pkg::OP_FINISH: state_next = lru_pkg::ST_FRD;
            lru_pkg::OP_DEACT:  state_next = lru_pkg::ST_ESCAN;
            default:            state_next = lru_pkg::ST_IDLE;
          endcase
        end
      lru_pkg::ST_LSCAN: if (!rd_vld && scan_end) state_next = lru_pkg::ST_LUPD;
      lru_pkg::ST_LUPD:  if (!rd_vld && scan_end) state_next = lru_pkg::ST_LRES;
      lru_pkg::ST_LRES:  state_next = lru_pkg::ST_OUT;
      lru_pkg::ST_FRD:   state_next = lru_pkg::ST_FWR;
      lru_pkg::ST_FWR:   state_next = lru_pkg::ST_ESCAN;
      lru_pkg::ST_ESCAN: if (!rd_vld && scan_end) state_next = lru_pkg::ST_EDO;
      lru_pkg::ST_EDO:
        if (edo_go) state_next = evict_now ? lru_pkg::ST_ESCAN : lru_pkg::ST_OUT;
      lru_pkg::ST_OUT:   if (!out_busy) state_next = lru_pkg::ST_IDLE;
      default:           state_next = lru_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lru_pkg::ST_IDLE;
    else state <= state_next;
  end

  // rank memory write: update pass of locate
  logic [SB-1:0] new_rank;
  always_comb begin
    new_rank = r_rdata;
    if (hit) begin
      if (rd_slot == hit_slot) new_rank = '0;
      else if (r_rdata < hit_rank) new_rank = r_rdata + 1'b1;
    end else begin
      if (rd_slot == free_slot) new_rank = '0;
      else new_rank = r_rdata + 1'b1;
    end
  end
  logic do_create;
  assign do_create = !hit && create_ok && free_ok;
  always_comb begin
    r_we = 1'b0;
    r_waddr = rd_slot;
    r_wdata = new_rank;
    if (state == lru_pkg::ST_LUPD && rd_vld && (hit || do_create)) begin
      if (valid[rd_slot] || (!hit && rd_slot == free_slot)) r_we = 1'b1;
    end
    k_we = (state == lru_pkg::ST_LRES) && do_create;
    k_waddr = free_slot;
    k_wdata = key;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < lru_pkg::Capacity; i++) cnt[i] <= '0;
      occ <= '0;
      deact <= 1'b0;
      limit <= OB'(lru_pkg::Capacity);
      out_busy <= 1'b0;
      rd_vld <= 1'b0;
      scan <= '0;
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      // hold the result until the receiver takes it
      if (out_load) out_busy <= 1'b1;
      else if (m_axis_tready) out_busy <= 1'b0;
      // scan pipeline
      rd_vld <= scan_run;
      if (scan_run) begin
        rd_slot <= scan[SB-1:0];
        scan <= scan + 1'b1;
      end
      unique case (state)
        lru_pkg::ST_IDLE: begin
          scan <= '0;
          hit <= 1'b0;
          tail_ok <= 1'b0;
          nev <= 1'b0;
          if (s_axis_tvalid) begin
            key <= s_axis_tdata[33:2];
            create_ok <= s_axis_tdata[34];
            handle <= s_axis_tdata[38:35];
            if (s_axis_tdata[1:0] == lru_pkg::OP_DEACT) begin
              deact <= 1'b1;
              tries <= (occ > '0) ? occ : '0;
            end
          end
        end
        lru_pkg::ST_LSCAN: begin
          if (rd_vld && valid[rd_slot] && k_rdata == key) begin
            hit <= 1'b1;
            hit_slot <= rd_slot;
            hit_rank <= r_rdata;
          end
          if (!rd_vld && scan_end) scan <= '0;
        end
        lru_pkg::ST_LUPD: ;
        lru_pkg::ST_LRES: begin
          m_axis_tuser <= lru_pkg::KIND_LOCATE;
          m_axis_tlast <= 1'b1;
          if (hit) begin
            if (cnt[hit_slot] != lru_pkg::CountMax) cnt[hit_slot] <= cnt[hit_slot] + 1'b1;
            m_axis_tdata <= {34'd0, hit_slot, 2'b11};
          end else if (do_create) begin
            valid[free_slot] <= 1'b1;
            cnt[free_slot] <= CB'(1);
            occ <= occ + 1'b1;
            m_axis_tdata <= {34'd0, free_slot, 2'b10};
          end else begin
            m_axis_tdata <= '0;
          end
        end
        lru_pkg::ST_FRD: begin
          if (valid[handle] && cnt[handle] != '0) cnt[handle] <= cnt[handle] - 1'b1;
        end
        lru_pkg::ST_FWR: begin
          tries <= (occ > eff_limit) ? occ - eff_limit : '0;
          scan <= '0;
        end
        lru_pkg::ST_ESCAN: begin
          if (rd_vld && valid[rd_slot] && {1'b0, r_rdata} == occ - 1'b1) begin
            tail_ok <= 1'b1;
            tail <= rd_slot;
          end
        end
        lru_pkg::ST_EDO: begin
          if (edo_go) begin
            // drop the tail entry, hold its result and rescan for the next tail
            if (evict_now) begin
              valid[tail] <= 1'b0;
              occ <= occ - 1'b1;
              tries <= tries - 1'b1;
              nev <= 1'b1;
              hold_slot <= tail;
              hold_key <= k_rdata_tail;
              scan <= '0;
              tail_ok <= 1'b0;
            end
            // send the held eviction, or the empty answer
            if (edo_emit) begin
              m_axis_tuser <= nev ? lru_pkg::KIND_EVICT : lru_pkg::KIND_NONE;
              m_axis_tdata <= nev ? {2'b00, hold_key, hold_slot, 2'b00} : '0;
              m_axis_tlast <= !evict_now;
            end
          end
        end
        lru_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  // hold the key of the tail candidate seen during the scan
  always_ff @(posedge clk) begin
    if (state == lru_pkg::ST_ESCAN && rd_vld && valid[rd_slot] &&
        {1'b0, r_rdata} == occ - 1'b1)
      k_rdata_tail <= k_rdata;
  end
endmodule

// File: hw/rtl/lru_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module lru_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/lru_checker.sv
// Port-level checker for the LRU table, bound to the top level.
// Depends on assert_macros.svh and lru_pkg.
`include "assert_macros.svh"
module lru_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  `CHK_IMPL(a_kind_ok, clk, rst, m_axis_tvalid, m_axis_tuser <= lru_pkg::KIND_NONE, "bad kind")
  `CHK_IMPL(a_loc_last, clk, rst, m_axis_tvalid && m_axis_tuser == lru_pkg::KIND_LOCATE,
    m_axis_tlast, "locate not last")
  `CHK_IMPL(a_none_last, clk, rst, m_axis_tvalid && m_axis_tuser == lru_pkg::KIND_NONE,
    m_axis_tlast, "none not last")
  `CHK_NEXT(a_busy, clk, rst,
    s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != lru_pkg::OP_UNUSED,
    !s_axis_tready, "accepted twice")
endmodule

bind lru_evictor_with_pin_counts lru_checker u_chk (.*);
